@@ sv/mmc_pkg.sv @@
// Shared constants and types for the mailbox message counter.
// No dependencies; imported by every module of the block but mmc_fifo.
package mmc_pkg;

  localparam logic [7:0] CHAR_NL = 8'h0a;

  // Last byte position of each line prefix ("From " and "Status: R").
  localparam logic [3:0] FROM_LAST   = 4'd4;
  localparam logic [3:0] STATUS_LAST = 4'd8;
  localparam logic [3:0] LINE_POS_MAX = 4'd15;

  localparam int BOX_BITS   = 3;
  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    CHG_NONE  = 2'd0,
    CHG_OTHER = 2'd1,
    CHG_NEW   = 2'd2
  } change_e;

  function automatic logic [7:0] from_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "F";
      4'd1:    c = "r";
      4'd2:    c = "o";
      4'd3:    c = "m";
      4'd4:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] status_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "S";
      4'd1:    c = "t";
      4'd2:    c = "a";
      4'd3:    c = "t";
      4'd4:    c = "u";
      4'd5:    c = "s";
      4'd6:    c = ":";
      4'd7:    c = " ";
      4'd8:    c = "R";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/mmc_fifo.sv @@
// Small register queue used between the block's stages and at its output.
// No package dependencies.
module mmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ sv/mmc_front.sv @@
// Line scanner: classifies each byte of the mailbox file and keeps the
// per-file From and read-Status counts. Depends on mmc_pkg.
module mmc_front import mmc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            mail_byte_i,
  input  logic                  end_of_file_i,
  output logic                  done_o,
  output logic [COUNT_BITS-1:0] from_lines_o,
  output logic [COUNT_BITS-1:0] read_lines_o
);

  logic                  inside_q, inside_d;
  logic                  may_start_q, may_start_d;
  logic [3:0]            pos_q, pos_d;
  logic                  from_alive_q, from_alive_d;
  logic                  status_alive_q, status_alive_d;
  logic                  decided_q, decided_d;
  logic [COUNT_BITS-1:0] from_q, from_d;
  logic [COUNT_BITS-1:0] read_q, read_d;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v != '1) ? v + 1'b1 : v;
  endfunction

  always_comb begin
    inside_d       = inside_q;
    may_start_d    = may_start_q;
    pos_d          = pos_q;
    from_alive_d   = from_alive_q;
    status_alive_d = status_alive_q;
    decided_d      = decided_q;
    from_d         = from_q;
    read_d         = read_q;

    if (pos_q == '0 && mail_byte_i == CHAR_NL) begin
      // empty line: close the header, or re-arm header start
      if (inside_q) inside_d = 1'b0;
      else          may_start_d = 1'b1;
      pos_d          = '0;
      from_alive_d   = 1'b1;
      status_alive_d = 1'b1;
      decided_d      = 1'b0;
    end else begin
      if (from_alive_q && pos_q <= FROM_LAST) begin
        if (mail_byte_i == from_char(pos_q)) begin
          if (pos_q == FROM_LAST) begin
            if (may_start_q) inside_d = 1'b1;
            if (inside_d)    from_d = bump(from_q);
            decided_d = 1'b1;
          end
        end else begin
          from_alive_d = 1'b0;
        end
      end
      // any other line blocks a new header
      if (!from_alive_d && !decided_d) begin
        may_start_d = 1'b0;
        decided_d   = 1'b1;
      end
      if (status_alive_q && pos_q <= STATUS_LAST) begin
        if (mail_byte_i == status_char(pos_q)) begin
          if (pos_q == STATUS_LAST && inside_d) read_d = bump(read_q);
        end else begin
          status_alive_d = 1'b0;
        end
      end
      if (mail_byte_i == CHAR_NL) begin
        pos_d          = '0;
        from_alive_d   = 1'b1;
        status_alive_d = 1'b1;
        decided_d      = 1'b0;
      end else if (pos_q < LINE_POS_MAX) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign done_o       = accept_i && end_of_file_i;
  assign from_lines_o = from_d;
  assign read_lines_o = read_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q       <= 1'b0;
      may_start_q    <= 1'b1;
      pos_q          <= '0;
      from_alive_q   <= 1'b1;
      status_alive_q <= 1'b1;
      decided_q      <= 1'b0;
      from_q         <= '0;
      read_q         <= '0;
    end else if (accept_i) begin
      if (end_of_file_i) begin
        // restart the scan for the next file
        inside_q       <= 1'b0;
        may_start_q    <= 1'b1;
        pos_q          <= '0;
        from_alive_q   <= 1'b1;
        status_alive_q <= 1'b1;
        decided_q      <= 1'b0;
        from_q         <= '0;
        read_q         <= '0;
      end else begin
        inside_q       <= inside_d;
        may_start_q    <= may_start_d;
        pos_q          <= pos_d;
        from_alive_q   <= from_alive_d;
        status_alive_q <= status_alive_d;
        decided_q      <= decided_d;
        from_q         <= from_d;
        read_q         <= read_d;
      end
    end
  end

endmodule

@@ sv/mmc_back.sv @@
// Result stage: compares a finished scan with the counts stored for its
// mailbox, updates the store and forms the change code. Depends on mmc_pkg.
module mmc_back import mmc_pkg::*; #(
  parameter int MAILBOXES  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  scan_empty_i,
  input  logic [BOX_BITS-1:0]   scan_box_i,
  input  logic [COUNT_BITS-1:0] scan_from_i,
  input  logic [COUNT_BITS-1:0] scan_read_i,
  output logic                  scan_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output logic [FIELD_BITS-1:0] res_total_o,
  output logic [FIELD_BITS-1:0] res_unread_o,
  output logic [1:0]            res_code_o
);

  localparam int BOX_W = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;

  function automatic logic [BOX_W-1:0] box_index(input logic [BOX_BITS-1:0] b);
    logic [6:0] r;
    r = 7'(b);
    for (int i = 0; i < 8; i++) begin
      if (r >= 7'(MAILBOXES)) r = r - 7'(MAILBOXES);
    end
    return r[BOX_W-1:0];
  endfunction

  logic [2*COUNT_BITS-1:0] prev_mem [MAILBOXES];
  logic [MAILBOXES-1:0]    known_q;
  logic [2*COUNT_BITS-1:0] prev_q;
  logic                    b_valid_q;
  logic [BOX_W-1:0]        b_box_q;
  logic [COUNT_BITS-1:0]   b_total_q, b_unread_q;

  logic [BOX_W-1:0]        head_box;
  logic [COUNT_BITS-1:0]   head_unread;
  logic                    b_fire, advance;
  logic [COUNT_BITS-1:0]   prev_total, prev_unread;
  logic                    known;
  change_e                 code;
  logic [31:0]             total_ext, unread_ext;

  assign head_box    = box_index(scan_box_i);
  assign head_unread = (scan_from_i > scan_read_i) ? scan_from_i - scan_read_i : '0;
  assign b_fire      = b_valid_q && !res_full_i;
  assign advance     = !scan_empty_i && (!b_valid_q || !res_full_i);
  assign scan_pop_o  = advance;

  assign prev_total  = prev_q[2*COUNT_BITS-1:COUNT_BITS];
  assign prev_unread = prev_q[COUNT_BITS-1:0];
  assign known       = known_q[b_box_q];

  always_comb begin
    priority if (b_unread_q != '0 && (!known || b_unread_q > prev_unread)) begin
      code = CHG_NEW;
    end else if (!known || b_unread_q < prev_unread || b_total_q != prev_total) begin
      code = CHG_OTHER;
    end else begin
      code = CHG_NONE;
    end
  end

  assign total_ext    = 32'(b_total_q);
  assign unread_ext   = 32'(b_unread_q);
  assign res_push_o   = b_fire;
  assign res_total_o  = total_ext[FIELD_BITS-1:0];
  assign res_unread_o = unread_ext[FIELD_BITS-1:0];
  assign res_code_o   = code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      known_q   <= '0;
    end else begin
      if (advance)     b_valid_q <= 1'b1;
      else if (b_fire) b_valid_q <= 1'b0;
      if (b_fire) known_q[b_box_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) prev_mem[b_box_q] <= {b_total_q, b_unread_q};
    if (advance) begin
      b_box_q    <= head_box;
      b_total_q  <= scan_from_i;
      b_unread_q <= head_unread;
      // forward the entry being written this cycle
      if (b_fire && b_box_q == head_box) prev_q <= {b_total_q, b_unread_q};
      else                               prev_q <= prev_mem[head_box];
    end
  end

endmodule

@@ sv/mbox_message_counter.sv @@
// Top level of the mailbox message counter: scanner, scan queue, result
// stage and result queue. Depends on mmc_pkg, mmc_front, mmc_fifo, mmc_back.
//
// Usage:
//   Input channel: one byte of a mailbox file per beat, with its mailbox
//   number and an end-of-file flag. A beat is taken when push is high and
//   full is low. Only the end-of-file beat yields a result.
//   Result channel: total and unread message counts and a change code
//   against the previous scan of the same mailbox (0 unchanged, 1 changed
//   without new mail, 2 new mail). The head result is on the ports while
//   empty is low and leaves on a beat with pop high.
//   Throughput: one byte per cycle while full is low; the result stage
//   handles one file per cycle while the result queue has room.
//   A result passes the scan queue, result-stage register and result queue.
//   Stall: the result queue holds two results and the scan queue two
//   finished files; full follows the scan queue and holds the byte stream.
//   Reset: clears the scan, both queues and the per-mailbox known flags;
//   the first scan of every mailbox reports as changed.
module mbox_message_counter import mmc_pkg::*; #(
  parameter int MAILBOXES  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            mail_byte_i,
  input  logic [BOX_BITS-1:0]   box_number_i,
  input  logic                  end_of_file_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [FIELD_BITS-1:0] total_messages_o,
  output logic [FIELD_BITS-1:0] unread_messages_o,
  output logic [1:0]            change_code_o
);

  localparam int SCAN_W = BOX_BITS + 2 * COUNT_BITS;
  localparam int RES_W  = 2 * FIELD_BITS + 2;

  logic                  accept, done;
  logic [COUNT_BITS-1:0] from_lines, read_lines;
  logic                  scan_empty, scan_pop;
  logic [SCAN_W-1:0]     scan_head;
  logic                  res_full, res_push;
  logic [FIELD_BITS-1:0] res_total, res_unread;
  logic [1:0]            res_code;
  logic [RES_W-1:0]      res_head;

  assign accept = push && !full;

  mmc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mail_byte_i   (mail_byte_i),
    .end_of_file_i (end_of_file_i),
    .done_o        (done),
    .from_lines_o  (from_lines),
    .read_lines_o  (read_lines)
  );

  mmc_fifo #(.WIDTH(SCAN_W), .DEPTH(2)) u_scan_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (done),
    .full_o  (full),
    .data_i  ({box_number_i, from_lines, read_lines}),
    .pop_i   (scan_pop),
    .empty_o (scan_empty),
    .data_o  (scan_head)
  );

  mmc_back #(.MAILBOXES(MAILBOXES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_empty_i (scan_empty),
    .scan_box_i   (scan_head[SCAN_W-1 -: BOX_BITS]),
    .scan_from_i  (scan_head[2*COUNT_BITS-1 -: COUNT_BITS]),
    .scan_read_i  (scan_head[COUNT_BITS-1:0]),
    .scan_pop_o   (scan_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_total_o  (res_total),
    .res_unread_o (res_unread),
    .res_code_o   (res_code)
  );

  mmc_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  ({res_total, res_unread, res_code}),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_head)
  );

  assign total_messages_o  = res_head[RES_W-1 -: FIELD_BITS];
  assign unread_messages_o = res_head[2*FIELD_BITS+1-FIELD_BITS -: FIELD_BITS];
  assign change_code_o     = res_head[1:0];

endmodule

@@ sv/mmc_checker.sv @@
// Port-level checks for the mailbox message counter, bound to the top level.
// Depends on mmc_pkg.
module mmc_checker import mmc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [FIELD_BITS-1:0] total_messages_o,
  input logic [FIELD_BITS-1:0] unread_messages_o,
  input logic [1:0]            change_code_o
);

  localparam bit UNMASKED = (COUNT_BITS <= FIELD_BITS);

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result pending right after reset");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (change_code_o == CHG_NONE || change_code_o == CHG_OTHER ||
                change_code_o == CHG_NEW))
    else $error("illegal change code");

  a_unread_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && UNMASKED) |-> unread_messages_o <= total_messages_o)
    else $error("unread count above total");

  a_new_has_unread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && UNMASKED && change_code_o == CHG_NEW) |-> unread_messages_o != '0)
    else $error("new mail reported with no unread messages");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(total_messages_o) &&
                          $stable(unread_messages_o) && $stable(change_code_o)))
    else $error("stalled result changed");

endmodule

bind mbox_message_counter mmc_checker #(.COUNT_BITS(COUNT_BITS)) u_mmc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .empty             (empty),
  .pop               (pop),
  .total_messages_o  (total_messages_o),
  .unread_messages_o (unread_messages_o),
  .change_code_o     (change_code_o)
);

@@ verif/mbox_message_counter_tb.sv @@
// Self-checking testbench for mbox_message_counter: directed mailbox files and
// random mailbox traffic, checked by a scan model or, for typed rows, by the table.
// Depends on mmc_pkg and the mbox_message_counter RTL.
module mbox_message_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmc_pkg::*;

  localparam int                    STALL_LIMIT  = 1000;
  localparam int                    RANDOM_BYTES = 1400;
  localparam int                    ROW_CHARS    = 24;
  localparam logic [39:0]           FROM_TXT     = "From ";
  localparam logic [71:0]           STATUS_TXT   = "Status: R";
  localparam logic [FIELD_BITS-1:0] COUNT_MAX    = '1;
  // Table rows cannot hold a zero byte, so this character stands in for one.
  localparam logic [7:0]            NUL_MARK     = "~";

  typedef struct packed {
    logic [FIELD_BITS-1:0] total;
    logic [FIELD_BITS-1:0] unread;
    change_e               code;
  } mbox_report_t;

  typedef struct packed {
    logic [8*ROW_CHARS-1:0] text;
    logic [BOX_BITS-1:0]    box;
    logic                   eof;
    logic                   typed;
    mbox_report_t           report;
  } mail_row_t;

  localparam mbox_report_t NO_REPORT = '{'0, '0, CHG_NONE};

  // Text is sent in order; eof marks the last byte of the row as end of file.
  localparam mail_row_t DIRECTED [0:24] = '{
    '{"\n",                      3'd0, 1'b1, 1'b1, '{16'd0, 16'd0, CHG_OTHER}},
    '{"\n",                      3'd0, 1'b1, 1'b1, '{16'd0, 16'd0, CHG_NONE}},
    '{"From a@b Mon\n",          3'd1, 1'b0, 1'b0, NO_REPORT},
    '{"Status: R\n",             3'd1, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd1, 1'b0, 1'b0, NO_REPORT},
    '{"From c\n",                3'd1, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd1, 1'b1, 1'b0, NO_REPORT},
    '{"From x\n",                3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"Subject: hi\n",           3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"body line runs long.\n",  3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"From y\n",                3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"Status: RO\n",            3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"Status: R\n",             3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"Frox m\n",                3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"Status: X~\377\n",        3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"From z",                  3'd7, 1'b1, 1'b0, NO_REPORT},
    '{"From q\nStatus: O\n",     3'd2, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd2, 1'b1, 1'b0, NO_REPORT},
    '{"From a\nFrom b\n",        3'd1, 1'b0, 1'b0, NO_REPORT},
    '{"\n",                      3'd1, 1'b1, 1'b0, NO_REPORT},
    '{"From a\nStatus: R\n",     3'd1, 1'b1, 1'b0, NO_REPORT},
    '{"\377\377\377\377~~~~\n",  3'd3, 1'b1, 1'b1, '{16'd0, 16'd0, CHG_OTHER}}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  push          = 1'b0;
  logic                  full;
  logic [7:0]            mail_byte_i   = '0;
  logic [BOX_BITS-1:0]   box_number_i  = '0;
  logic                  end_of_file_i = 1'b0;
  logic                  empty;
  logic                  pop           = 1'b0;
  logic [FIELD_BITS-1:0] total_messages_o;
  logic [FIELD_BITS-1:0] unread_messages_o;
  logic [1:0]            change_code_o;

  // Scan model state
  logic                  in_hdr, hdr_may_open, from_alive, status_alive, line_done;
  logic [3:0]            line_pos;
  logic [FIELD_BITS-1:0] from_cnt, read_cnt;
  logic [FIELD_BITS-1:0] last_total  [1<<BOX_BITS];
  logic [FIELD_BITS-1:0] last_unread [1<<BOX_BITS];
  logic                  last_seen   [1<<BOX_BITS];

  mbox_report_t pending_reports[$];
  mbox_report_t typed_report;
  logic         typed_on = 1'b0;
  logic         idle_on  = 1'b1;
  logic [7:0]   file_bytes[$];
  int           failures        = 0;
  int           bytes_in        = 0;
  int           files_closed    = 0;
  int           reports_checked = 0;
  int           quiet_cycles    = 0;

  mbox_message_counter u_dut (
    .clk_i, .rst_ni, .push, .full, .mail_byte_i, .box_number_i, .end_of_file_i,
    .empty, .pop, .total_messages_o, .unread_messages_o, .change_code_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_line();
    line_pos     = '0;
    from_alive   = 1'b1;
    status_alive = 1'b1;
    line_done    = 1'b0;
  endfunction

  function automatic void restart_scan();
    in_hdr       = 1'b0;
    hdr_may_open = 1'b1;
    from_cnt     = '0;
    read_cnt     = '0;
    restart_line();
  endfunction

  // Advance the scan by one byte; returns 1 with the report on an end-of-file byte.
  function automatic logic scan_mail_byte(input logic [7:0] b,
                                          input logic [BOX_BITS-1:0] box,
                                          input logic eof, output mbox_report_t rep);
    int                    pos;
    logic [FIELD_BITS-1:0] unread;
    pos = int'(line_pos);
    rep = NO_REPORT;
    if (pos == 0 && b == CHAR_NL) begin
      if (in_hdr) in_hdr = 1'b0;
      else hdr_may_open = 1'b1;
      restart_line();
    end else begin
      if (from_alive && pos <= int'(FROM_LAST)) begin
        if (b != FROM_TXT[8*(int'(FROM_LAST)-pos) +: 8]) begin
          from_alive = 1'b0;
        end else if (pos == int'(FROM_LAST)) begin
          if (hdr_may_open) in_hdr = 1'b1;
          if (in_hdr && from_cnt != COUNT_MAX) from_cnt++;
          line_done = 1'b1;
        end
      end
      // Any line that is not a From line blocks the next header.
      if (!from_alive && !line_done) begin
        hdr_may_open = 1'b0;
        line_done    = 1'b1;
      end
      if (status_alive && pos <= int'(STATUS_LAST)) begin
        if (b != STATUS_TXT[8*(int'(STATUS_LAST)-pos) +: 8]) status_alive = 1'b0;
        else if (pos == int'(STATUS_LAST) && in_hdr && read_cnt != COUNT_MAX) read_cnt++;
      end
      if (b == CHAR_NL) restart_line();
      else if (line_pos != LINE_POS_MAX) line_pos++;
    end
    if (!eof) return 1'b0;

    unread     = (from_cnt > read_cnt) ? from_cnt - read_cnt : '0;
    rep.total  = from_cnt;
    rep.unread = unread;
    if (unread != 0 && (!last_seen[box] || unread > last_unread[box])) begin
      rep.code = CHG_NEW;
    end else if (!last_seen[box] || unread < last_unread[box] ||
                 from_cnt != last_total[box]) begin
      rep.code = CHG_OTHER;
    end else begin
      rep.code = CHG_NONE;
    end
    last_total[box]  = from_cnt;
    last_unread[box] = unread;
    last_seen[box]   = 1'b1;
    restart_scan();
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    if (failures < 10) $display("%0t ns: MISMATCH %s", $time, msg);
    failures++;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  // Mostly lowercase letters, now and then any byte value.
  function automatic void add_word(input int max_len);
    repeat ($urandom_range(0, max_len))
      file_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(97, 122)));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic push_beat(input logic [7:0] b, input logic [BOX_BITS-1:0] box,
                           input logic eof);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    push          <= 1'b1;
    mail_byte_i   <= b;
    box_number_i  <= box;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every report is in.
  task automatic drain_reports();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_reports.size() != 0);
  endtask

  // Result side: stall in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Check results, predict on accepted bytes, and watch for a stalled run.
  always @(posedge clk_i) begin
    mbox_report_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("unexpected report: total %0d unread %0d code %0d",
                                 total_messages_o, unread_messages_o, change_code_o));
        end else begin
          want = pending_reports.pop_front();
          reports_checked++;
          if (total_messages_o !== want.total || unread_messages_o !== want.unread ||
              change_code_o !== want.code)
            note_failure($sformatf(
                "report %0d: expected total %0d unread %0d code %0d, got %0d %0d %0d",
                reports_checked, want.total, want.unread, want.code,
                total_messages_o, unread_messages_o, change_code_o));
        end
      end
      if (push && !full) begin
        bytes_in++;
        if (scan_mail_byte(mail_byte_i, box_number_i, end_of_file_i, got)) begin
          files_closed++;
          pending_reports.push_back(typed_on ? typed_report : got);
        end
      end
      if ((pop && !empty) || (push && !full)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat on either side for %0d cycles", $time, STALL_LIMIT);
        $display("mbox_message_counter verification failed");
        $finish;
      end
    end
  end

  initial begin
    mail_row_t           row;
    int                  first;
    logic [7:0]          ch;
    logic                last;
    int                  files;
    int                  base;
    int                  kind;
    logic [BOX_BITS-1:0] eof_box;

    restart_scan();
    for (int i = 0; i < (1 << BOX_BITS); i++) begin
      last_total[i]  = '0;
      last_unread[i] = '0;
      last_seen[i]   = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed files from the table
    foreach (DIRECTED[r]) begin
      row   = DIRECTED[r];
      first = 0;
      while (row.text[8*(ROW_CHARS-1-first) +: 8] == 8'h00) first++;
      for (int k = first; k < ROW_CHARS; k++) begin
        ch           = row.text[8*(ROW_CHARS-1-k) +: 8];
        last         = row.eof && k == ROW_CHARS - 1;
        typed_on     = last && row.typed;
        typed_report = row.report;
        push_beat((ch == NUL_MARK) ? 8'h00 : ch, row.box, last);
      end
    end
    typed_on = 1'b0;
    drain_reports();

    // Random mailbox files: mostly well-formed messages, some noise.
    files = 0;
    base  = bytes_in;
    while (bytes_in - base < RANDOM_BYTES || files < 16) begin
      file_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
      end else begin
        if (kind == 1) begin
          add_word(8);
          add_text("\n");
        end
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 7))
            0: add_text("from x\n");
            1: add_text("Fro");
            default: begin
              add_text("From ");
              add_word(6);
              add_text("\n");
            end
          endcase
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
              0, 1: add_text("Status: R\n");
              2: add_text("Status: RO\n");
              3: add_text("Status: O\n");
              4: add_text("Status:R\n");
              default: begin
                add_word(6);
                add_text(": v\n");
              end
            endcase
          end
          if ($urandom_range(0, 9) != 0) add_text("\n");
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
              0: add_text("From the body\n");
              1: add_text("\n");
              2: begin
                add_word(30);
                add_text("\n");
              end
              default: begin
                add_word(8);
                add_text("\n");
              end
            endcase
          end
          if ($urandom_range(0, 7) != 0) add_text("\n");
        end
        // Drop the last newline now and then to leave the final line open.
        if (file_bytes.size() != 0 && $urandom_range(0, 3) == 0) void'(file_bytes.pop_back());
      end
      if (file_bytes.size() == 0) file_bytes.push_back(CHAR_NL);

      eof_box = BOX_BITS'($urandom_range(0, (1 << BOX_BITS) - 1));
      foreach (file_bytes[k])
        push_beat(file_bytes[k],
                  (k == file_bytes.size() - 1) ? eof_box : BOX_BITS'($urandom),
                  k == file_bytes.size() - 1);
      files++;
      if (files % 12 == 11) drain_reports();
      if (bytes_in - base >= RANDOM_BYTES * 85 / 100) idle_on = 1'b0;
    end

    drain_reports();
    repeat (10) @(negedge clk_i);

    $display("Covered %0d mailbox files in %0d bytes; %0d reports checked, %0d mismatches.",
             files_closed, bytes_in, reports_checked, failures);
    $display("Included first and repeat scans per mailbox, open last lines and long lines.");
    if (failures == 0) $display("mbox_message_counter verification clean");
    else $display("mbox_message_counter verification failed");
    $finish;
  end

endmodule
